>>> rtl/gesr_pkg.sv
// shared types, codes and constants of the graph edge store
`timescale 1ns / 1ps

package gesr_pkg;

   localparam int VERTEX_W = 6;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 10;
   localparam int MASK_W   = 64;
   localparam int CFG_W    = 7;

   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_MAX_EDGES    = 1024;

   localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 7'd64;

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FIND  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REACH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_LOOP  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [VERTEX_W-1:0] src_vertex;
      logic [VERTEX_W-1:0] dst_vertex;
   } gesr_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [INDEX_W-1:0]  edge_index;
      logic [MASK_W-1:0]   reach_mask;
   } gesr_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FSCAN,
      S_POP,
      S_LOAD,
      S_WSCAN,
      S_FINISH
   } gesr_state_type;

   // conditions from the datapath to the sequencer
   typedef struct packed {
      logic req_beat;
      logic go_find;
      logic go_walk;
      logic find_hit;
      logic scan_done;
      logic stack_empty;
      logic slot_free;
   } gesr_cond_type;

   // controls from the sequencer to the datapath
   typedef struct packed {
      logic accept;
      logic decode;
      logic fscan;
      logic wscan;
      logic pop;
      logic load;
      logic emit;
   } gesr_ctrl_type;

endpackage

>>> rtl/graph_edge_store_reachability.sv
// graph edge store with edge find and depth-first reachability
//
//   beat    direction  handshake          payload
//   req     in         req_valid/stall    command, src_vertex, dst_vertex
//   rsp     out        rsp_valid/stall    status, found, edge_index, reach_mask
//   csr     in         csr_wr_en          vertex_count
//
// one item at a time; req_stall is low only while the sequencer is idle.
// add and every error case go from decode straight to the finish state.
// find scans the edge table up to the first hit or its end; reach scans the
// whole table once per popped vertex through the single read port of the
// edge memory.
// synchronous reset empties the edge table and sets vertex_count to 64;
// no clearing pass. a stalled result holds while the next item is taken.
`timescale 1ns / 1ps

module graph_edge_store_reachability #(
   parameter int MAX_VERTICES = gesr_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = gesr_pkg::DEF_MAX_EDGES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  gesr_pkg::gesr_req_type           req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output gesr_pkg::gesr_rsp_type           rsp_payload,
   input  logic                             csr_wr_en,
   input  logic [gesr_pkg::CFG_W-1:0]       csr_wr_data
);

   import gesr_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int SW = $clog2(MAX_VERTICES + 1);
   localparam int AW = $clog2(MAX_EDGES);
   localparam int TW = $clog2(MAX_EDGES + 1);
   localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;

   gesr_cond_type cond;
   gesr_ctrl_type ctrl;

   logic [CFG_W-1:0]    vertex_count_ff, vertex_count_in;
   gesr_req_type        req_ff, req_in;
   logic [TW-1:0]       edge_total_ff, edge_total_in;
   logic [TW-1:0]       scan_addr_ff, scan_addr_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [AW-1:0]       data_addr_ff, data_addr_in;
   logic [VW-1:0]       key_src_ff, key_src_in;
   logic                walk_mode_ff, walk_mode_in;
   logic [SW-1:0]       depth_ff, depth_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       index_ff, index_in;
   logic                mask_en_ff, mask_en_in;
   logic                rsp_valid_ff, rsp_valid_in;
   gesr_rsp_type        rsp_ff, rsp_in;

   logic [CFG_W-1:0] limit;
   logic             src_bad;
   logic             dst_bad;
   logic             issuing;
   logic             hit;
   logic [SW-1:0]    depth_dec;
   logic [IW-1:0]    index_wide;
   logic [VW-1:0]    req_src;
   logic [VW-1:0]    req_dst;

   logic            edge_we;
   logic [AW-1:0]   edge_waddr;
   logic [2*VW-1:0] edge_wdata;
   logic [2*VW-1:0] edge_rdata;
   logic [VW-1:0]   entry_src;
   logic [VW-1:0]   entry_dst;

   logic            stack_we;
   logic [VW-1:0]   stack_waddr;
   logic [VW-1:0]   stack_wdata;
   logic [VW-1:0]   stack_raddr;
   logic [VW-1:0]   stack_rdata;

   gesr_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   gesr_ram #(
      .WIDTH (2 * VW),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (edge_wdata),
      .rd_addr (scan_addr_ff[AW-1:0]),
      .rd_data (edge_rdata)
   );

   gesr_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_VERTICES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   assign entry_src = edge_rdata[2*VW-1:VW];
   assign entry_dst = edge_rdata[VW-1:0];

   gesr_match #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_match (
      .walk_mode (walk_mode_ff),
      .entry_src (entry_src),
      .entry_dst (entry_dst),
      .key_src   (key_src_ff),
      .key_dst   (req_dst),
      .visited   (visited_ff),
      .hit       (hit)
   );

   // vertex limit is the smaller of the register and the build size
   assign limit = (vertex_count_ff < CFG_W'(MAX_VERTICES)) ? vertex_count_ff
                                                           : CFG_W'(MAX_VERTICES);
   assign src_bad = CFG_W'(req_ff.src_vertex) >= limit;
   assign dst_bad = CFG_W'(req_ff.dst_vertex) >= limit;
   assign req_src = req_ff.src_vertex[VW-1:0];
   assign req_dst = req_ff.dst_vertex[VW-1:0];

   assign issuing   = scan_addr_ff < edge_total_ff;
   assign depth_dec = depth_ff - SW'(1);
   assign index_wide = IW'(index_ff);

   assign cond.req_beat    = req_valid && !req_stall;
   assign cond.go_find     = (req_ff.command == CMD_FIND) && !src_bad && !dst_bad;
   assign cond.go_walk     = (req_ff.command == CMD_REACH) && !src_bad;
   assign cond.find_hit    = rd_pend_ff && hit;
   assign cond.scan_done   = !issuing && !rd_pend_ff;
   assign cond.stack_empty = (depth_ff == '0);
   assign cond.slot_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      vertex_count_in = vertex_count_ff;
      req_in          = req_ff;
      edge_total_in   = edge_total_ff;
      scan_addr_in    = scan_addr_ff;
      rd_pend_in      = 1'b0;
      data_addr_in    = data_addr_ff;
      key_src_in      = key_src_ff;
      walk_mode_in    = walk_mode_ff;
      depth_in        = depth_ff;
      visited_in      = visited_ff;
      status_in       = status_ff;
      found_in        = found_ff;
      index_in        = index_ff;
      mask_en_in      = mask_en_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in          = rsp_ff;

      edge_we     = 1'b0;
      edge_waddr  = edge_total_ff[AW-1:0];
      edge_wdata  = {req_src, req_dst};
      stack_we    = 1'b0;
      stack_waddr = '0;
      stack_wdata = req_src;
      stack_raddr = depth_dec[VW-1:0];

      if (csr_wr_en) begin
         vertex_count_in = csr_wr_data;
      end

      if (cond.req_beat) begin
         req_in = req_payload;
      end

      if (ctrl.decode) begin
         status_in    = STATUS_OK;
         found_in     = 1'b0;
         index_in     = '0;
         mask_en_in   = 1'b0;
         scan_addr_in = '0;
         key_src_in   = req_src;
         walk_mode_in = 1'b0;
         case (req_ff.command)
            CMD_ADD: begin
               if (src_bad || dst_bad) begin
                  status_in = STATUS_RANGE;
               end else if (req_ff.src_vertex == req_ff.dst_vertex) begin
                  status_in = STATUS_LOOP;
               end else if (edge_total_ff >= TW'(MAX_EDGES)) begin
                  status_in = STATUS_FULL;
               end else begin
                  edge_we       = 1'b1;
                  index_in      = edge_total_ff[AW-1:0];
                  edge_total_in = edge_total_ff + TW'(1);
               end
            end
            CMD_FIND: begin
               if (src_bad || dst_bad) status_in = STATUS_RANGE;
            end
            CMD_REACH: begin
               if (src_bad) begin
                  status_in = STATUS_RANGE;
               end else begin
                  // fresh walk: only the source is visited and on the stack
                  mask_en_in          = 1'b1;
                  walk_mode_in        = 1'b1;
                  visited_in          = '0;
                  visited_in[req_src] = 1'b1;
                  stack_we            = 1'b1;
                  stack_waddr         = '0;
                  stack_wdata         = req_src;
                  depth_in            = SW'(1);
               end
            end
            default: begin
            end
         endcase
      end

      // edge scan: address out this cycle, entry compared the next
      if (ctrl.fscan || ctrl.wscan) begin
         if (issuing) begin
            scan_addr_in = scan_addr_ff + TW'(1);
            rd_pend_in   = 1'b1;
            data_addr_in = scan_addr_ff[AW-1:0];
         end
      end

      if (ctrl.fscan && rd_pend_ff && hit) begin
         found_in = 1'b1;
         index_in = data_addr_ff;
      end

      if (ctrl.wscan && rd_pend_ff && hit && (depth_ff < SW'(MAX_VERTICES))) begin
         visited_in[entry_dst] = 1'b1;
         stack_we              = 1'b1;
         stack_waddr           = depth_ff[VW-1:0];
         stack_wdata           = entry_dst;
         depth_in              = depth_ff + SW'(1);
      end

      if (ctrl.pop) begin
         depth_in = depth_dec;
      end

      if (ctrl.load) begin
         key_src_in   = stack_rdata;
         scan_addr_in = '0;
      end

      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = status_ff;
         rsp_in.found      = found_ff;
         rsp_in.edge_index = index_wide[INDEX_W-1:0];
         rsp_in.reach_mask = mask_en_ff ? MASK_W'(visited_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
         edge_total_ff   <= '0;
         depth_ff        <= '0;
         rd_pend_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         vertex_count_ff <= vertex_count_in;
         edge_total_ff   <= edge_total_in;
         depth_ff        <= depth_in;
         rd_pend_ff      <= rd_pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      scan_addr_ff <= scan_addr_in;
      data_addr_ff <= data_addr_in;
      key_src_ff   <= key_src_in;
      walk_mode_ff <= walk_mode_in;
      visited_ff   <= visited_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      index_ff     <= index_in;
      mask_en_ff   <= mask_en_in;
      rsp_ff       <= rsp_in;
   end

   // no beat is taken while reset is held
   assign req_stall   = reset || !ctrl.accept;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= TW'(MAX_EDGES))
      else $error("edge count beyond table size");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= SW'(MAX_VERTICES))
      else $error("walk stack overflow");

   a_found_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |-> (rsp_ff.status == STATUS_OK && rsp_ff.reach_mask == '0))
      else $error("find result carries error status or reach mask");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      cond.req_beat |=> req_stall)
      else $error("second beat taken while an item is in progress");

endmodule

>>> rtl/gesr_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module gesr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/gesr_match.sv
// shared edge compare unit: find match or unvisited walk successor
`timescale 1ns / 1ps

module gesr_match #(
   parameter int MAX_VERTICES = gesr_pkg::DEF_MAX_VERTICES
) (
   input  logic                              walk_mode,
   input  logic [$clog2(MAX_VERTICES)-1:0]   entry_src,
   input  logic [$clog2(MAX_VERTICES)-1:0]   entry_dst,
   input  logic [$clog2(MAX_VERTICES)-1:0]   key_src,
   input  logic [$clog2(MAX_VERTICES)-1:0]   key_dst,
   input  logic [MAX_VERTICES-1:0]           visited,
   output logic                              hit
);

   import gesr_pkg::*;

   logic src_eq;

   assign src_eq = (entry_src == key_src);

   always_comb begin
      if (walk_mode) begin
         hit = src_eq && !visited[entry_dst];
      end else begin
         hit = src_eq && (entry_dst == key_dst);
      end
   end

endmodule

>>> rtl/gesr_seq.sv
// command sequencer of the graph edge store
`timescale 1ns / 1ps

module gesr_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  gesr_pkg::gesr_cond_type cond,
   output gesr_pkg::gesr_ctrl_type ctrl
);

   import gesr_pkg::*;

   gesr_state_type state_ff;
   gesr_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cond.req_beat) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (cond.go_find) state_in = S_FSCAN;
            else if (cond.go_walk) state_in = S_POP;
            else state_in = S_FINISH;
         end
         S_FSCAN: begin
            if (cond.find_hit || cond.scan_done) state_in = S_FINISH;
         end
         S_POP: begin
            if (cond.stack_empty) state_in = S_FINISH;
            else state_in = S_LOAD;
         end
         S_LOAD: begin
            state_in = S_WSCAN;
         end
         S_WSCAN: begin
            if (cond.scan_done) state_in = S_POP;
         end
         S_FINISH: begin
            if (cond.slot_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         S_IDLE:   ctrl.accept = 1'b1;
         S_DECODE: ctrl.decode = 1'b1;
         S_FSCAN:  ctrl.fscan  = 1'b1;
         S_POP:    ctrl.pop    = !cond.stack_empty;
         S_LOAD:   ctrl.load   = 1'b1;
         S_WSCAN:  ctrl.wscan  = 1'b1;
         S_FINISH: ctrl.emit   = cond.slot_free;
         default:  ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
